@@ design/gsm_pkg.sv @@
// Shared constants, command codes and controller/datapath interface types of the slot map.
package gsm_pkg;

    localparam int CAPACITY       = 256;
    localparam int SLOT_W         = 8;
    localparam int GEN_W          = 16;
    localparam int COUNT_W        = 9;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 2;
    localparam int VALUE_W        = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - SLOT_W - GEN_W - COUNT_W;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ERASE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd2;

    localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

    typedef struct packed {
        logic accept;
        logic insert_commit;
        logic full_reject;
        logic bad_cmd;
        logic save_look;
        logic verify_result;
        logic erase_unlink;
        logic erase_move;
        logic out_load;
    } gsm_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             full;
        logic             key_ok;
        logic             out_free;
    } gsm_sts_t;

endpackage

@@ design/generational_slot_map_unit.sv @@
// Top level of the generational slot map: stream ports, controller and datapath.
// One command is in flight at a time. An insert, a rejected insert or an unknown command
// passes through the look-up and done states to the output register, a check or an erase of
// an invalid key also through the verify state and an erase of a valid key through the verify
// and move states, as set by the chain of dependent single-port reads of the slot table and
// the dense store, one read a cycle. The input is ready again in the cycle after the result
// is loaded into the output register, and a stalled result holds the block for at most one
// further command. All tables come out of reset ready for use without a clearing pass.
module generational_slot_map_unit #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // value [31:0], key_slot [39:32], key_gen [55:40]
    input  logic [gsm_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd [1:0]
    input  logic [gsm_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_slot [7:0], out_gen [23:8], count [32:24], zero [39:33]
    output logic [gsm_pkg::M_TDATA_W-1:0] m_tdata,
    // status [1:0]
    output logic [gsm_pkg::STATUS_W-1:0]  m_tuser
);
    import gsm_pkg::*;

    gsm_ctl_t ctl;
    gsm_sts_t sts;

    logic [SLOT_W-1:0]  m_slot;
    logic [GEN_W-1:0]   m_gen;
    logic [COUNT_W-1:0] m_count;

    gsm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    gsm_datapath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .sts        (sts),
        .s_cmd      (s_tuser),
        .s_value    (s_tdata[VALUE_W-1:0]),
        .s_key_slot (s_tdata[VALUE_W+SLOT_W-1:VALUE_W]),
        .s_key_gen  (s_tdata[VALUE_W+SLOT_W+GEN_W-1:VALUE_W+SLOT_W]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_status   (m_tuser),
        .m_slot     (m_slot),
        .m_gen      (m_gen),
        .m_count    (m_count)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, m_count, m_gen, m_slot};

endmodule

@@ design/gsm_ctrl.sv @@
// Sequencing state machine of the slot map.
module gsm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  gsm_pkg::gsm_sts_t sts,
    output gsm_pkg::gsm_ctl_t ctl
);
    import gsm_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOK   = 3'd1;
    localparam logic [2:0] ST_VERIFY = 3'd2;
    localparam logic [2:0] ST_MOVE   = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        ctl        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.accept = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                state_next = ST_DONE;
                if (sts.op == CMD_INSERT) begin
                    if (sts.full) begin
                        ctl.full_reject = 1'b1;
                    end else begin
                        ctl.insert_commit = 1'b1;
                    end
                end else if (sts.op == CMD_ERASE || sts.op == CMD_CHECK) begin
                    ctl.save_look = 1'b1;
                    state_next    = ST_VERIFY;
                end else begin
                    ctl.bad_cmd = 1'b1;
                end
            end
            ST_VERIFY: begin
                if (sts.op == CMD_ERASE && sts.key_ok) begin
                    ctl.erase_unlink = 1'b1;
                    state_next       = ST_MOVE;
                end else begin
                    ctl.verify_result = 1'b1;
                    state_next        = ST_DONE;
                end
            end
            ST_MOVE: begin
                ctl.erase_move = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/gsm_datapath.sv @@
// Slot tables, dense store, free list, counters and result register of the slot map.
module gsm_datapath #(
    parameter int DATA_WIDTH = gsm_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  gsm_pkg::gsm_ctl_t            ctl,
    output gsm_pkg::gsm_sts_t            sts,
    input  logic [gsm_pkg::CMD_W-1:0]    s_cmd,
    input  logic [gsm_pkg::VALUE_W-1:0]  s_value,
    input  logic [gsm_pkg::SLOT_W-1:0]   s_key_slot,
    input  logic [gsm_pkg::GEN_W-1:0]    s_key_gen,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [gsm_pkg::STATUS_W-1:0] m_status,
    output logic [gsm_pkg::SLOT_W-1:0]   m_slot,
    output logic [gsm_pkg::GEN_W-1:0]    m_gen,
    output logic [gsm_pkg::COUNT_W-1:0]  m_count
);
    import gsm_pkg::*;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic [SLOT_W-1:0]     owner;
    } dense_entry_t;

    logic [SLOT_W-1:0]  link_mem  [CAPACITY];
    logic [GEN_W-1:0]   gen_mem   [CAPACITY];
    dense_entry_t       dense_mem [CAPACITY];
    logic [CAPACITY-1:0] slot_vld_reg;

    logic [CMD_W-1:0]      op_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    logic [SLOT_W-1:0]     kslot_reg;
    logic [GEN_W-1:0]      kgen_reg;
    logic [SLOT_W-1:0]     free_head_reg;
    logic [SLOT_W-1:0]     free_head_next;
    logic [COUNT_W-1:0]    live_reg;
    logic [COUNT_W-1:0]    live_next;
    logic [GEN_W-1:0]      gen_ctr_reg;
    logic [GEN_W-1:0]      gen_ctr_next;
    logic [SLOT_W-1:0]     link_rd_reg;
    logic [GEN_W-1:0]      gen_rd_reg;
    logic                  vld_rd_reg;
    logic [SLOT_W-1:0]     raddr_rd_reg;
    dense_entry_t          dense_rd_reg;
    logic [COUNT_W-1:0]    pos_reg;
    logic                  gen_match_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic [GEN_W-1:0]      res_gen_reg;
    logic                  m_valid_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [SLOT_W-1:0]     m_slot_reg;
    logic [GEN_W-1:0]      m_gen_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic [SLOT_W-1:0]  slot_raddr;
    logic [COUNT_W-1:0] link_eff;
    logic [GEN_W-1:0]   gen_eff;
    logic [COUNT_W-1:0] last_pos;
    logic [SLOT_W-1:0]  dense_raddr;
    logic               move_needed;
    logic               link_we;
    logic [SLOT_W-1:0]  link_waddr;
    logic [SLOT_W-1:0]  link_wdata;
    logic               gen_we;
    logic [SLOT_W-1:0]  gen_waddr;
    logic               dense_we;
    logic [SLOT_W-1:0]  dense_waddr;
    dense_entry_t       dense_wdata;

    // A slot that was never written reads as its reset contents: link i plus one, generation zero.
    assign slot_raddr  = (s_cmd == CMD_INSERT) ? free_head_reg : s_key_slot;
    assign link_eff    = vld_rd_reg ? COUNT_W'(link_rd_reg)
                                    : COUNT_W'(raddr_rd_reg) + COUNT_W'(1);
    assign gen_eff     = vld_rd_reg ? gen_rd_reg : '0;
    assign last_pos    = live_reg - COUNT_W'(1);
    assign dense_raddr = ctl.erase_unlink ? last_pos[SLOT_W-1:0] : link_eff[SLOT_W-1:0];
    assign move_needed = (pos_reg != last_pos);

    assign sts.op       = op_reg;
    assign sts.full     = (live_reg == CAP_COUNT);
    assign sts.key_ok   = gen_match_reg && (pos_reg < live_reg)
                          && (dense_rd_reg.owner == kslot_reg);
    assign sts.out_free = !m_valid_reg || m_ready;

    always_comb begin
        link_we = ctl.insert_commit || ctl.erase_unlink || (ctl.erase_move && move_needed);
        gen_we  = ctl.insert_commit || ctl.erase_unlink;
        priority if (ctl.insert_commit) begin
            link_waddr = free_head_reg;
            link_wdata = live_reg[SLOT_W-1:0];
        end else if (ctl.erase_unlink) begin
            link_waddr = kslot_reg;
            link_wdata = free_head_reg;
        end else begin
            link_waddr = dense_rd_reg.owner;
            link_wdata = pos_reg[SLOT_W-1:0];
        end
        gen_waddr = ctl.insert_commit ? free_head_reg : kslot_reg;
        dense_we  = ctl.insert_commit || (ctl.erase_move && move_needed);
        if (ctl.insert_commit) begin
            dense_waddr       = live_reg[SLOT_W-1:0];
            dense_wdata.value = value_reg;
            dense_wdata.owner = free_head_reg;
        end else begin
            dense_waddr = pos_reg[SLOT_W-1:0];
            dense_wdata = dense_rd_reg;
        end
    end

    always_comb begin
        free_head_next = free_head_reg;
        live_next      = live_reg;
        gen_ctr_next   = gen_ctr_reg;
        if (ctl.insert_commit) begin
            free_head_next = link_eff[SLOT_W-1:0];
            live_next      = live_reg + COUNT_W'(1);
            gen_ctr_next   = gen_ctr_reg + GEN_W'(1);
        end else if (ctl.erase_unlink) begin
            free_head_next = kslot_reg;
        end else if (ctl.erase_move) begin
            live_next    = last_pos;
            gen_ctr_next = gen_ctr_reg + GEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_head_reg <= '0;
            live_reg      <= '0;
            gen_ctr_reg   <= '0;
            slot_vld_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            free_head_reg <= free_head_next;
            live_reg      <= live_next;
            gen_ctr_reg   <= gen_ctr_next;
            if (gen_we) begin
                slot_vld_reg[gen_waddr] <= 1'b1;
            end
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        link_rd_reg  <= link_mem[slot_raddr];
        gen_rd_reg   <= gen_mem[slot_raddr];
        vld_rd_reg   <= slot_vld_reg[slot_raddr];
        raddr_rd_reg <= slot_raddr;
        dense_rd_reg <= dense_mem[dense_raddr];
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (gen_we) begin
            gen_mem[gen_waddr] <= gen_ctr_reg;
        end
        if (dense_we) begin
            dense_mem[dense_waddr] <= dense_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            op_reg    <= s_cmd;
            value_reg <= DATA_WIDTH'(s_value);
            kslot_reg <= s_key_slot;
            kgen_reg  <= s_key_gen;
        end
        if (ctl.save_look) begin
            pos_reg       <= link_eff;
            gen_match_reg <= (gen_eff == kgen_reg);
        end
        priority if (ctl.insert_commit) begin
            res_status_reg <= STATUS_OK;
            res_slot_reg   <= free_head_reg;
            res_gen_reg    <= gen_ctr_reg;
        end else if (ctl.full_reject) begin
            res_status_reg <= STATUS_FULL;
            res_slot_reg   <= '0;
            res_gen_reg    <= '0;
        end else if (ctl.bad_cmd) begin
            res_status_reg <= STATUS_INVALID;
            res_slot_reg   <= '0;
            res_gen_reg    <= '0;
        end else if (ctl.verify_result) begin
            res_status_reg <= sts.key_ok ? STATUS_OK : STATUS_INVALID;
            res_slot_reg   <= '0;
            res_gen_reg    <= '0;
        end else if (ctl.erase_move) begin
            res_status_reg <= STATUS_OK;
            res_slot_reg   <= '0;
            res_gen_reg    <= '0;
        end else begin
            res_status_reg <= res_status_reg;
        end
        if (ctl.out_load) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_gen_reg    <= res_gen_reg;
            m_count_reg  <= live_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_slot   = m_slot_reg;
    assign m_gen    = m_gen_reg;
    assign m_count  = m_count_reg;

endmodule

@@ design/gsm_checker.sv @@
// Port-level assertions of the slot map and their binding to the top level.
module gsm_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [gsm_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [gsm_pkg::STATUS_W-1:0]  m_tuser
);
    import gsm_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result changed while stalled.");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == STATUS_FULL |-> m_tdata[32:24] == CAP_COUNT)
        else $error("Full status with a count below capacity.");

    a_fail_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |-> m_tdata[23:0] == '0)
        else $error("Failed operation returned a key.");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[32:24] <= CAP_COUNT && m_tuser <= STATUS_INVALID)
        else $error("Count above capacity or undefined status.");

endmodule

bind generational_slot_map_unit gsm_checker u_gsm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
